>>> hdl/grd_pkg.sv
// shared types, constants and helpers for the grid run detector
`default_nettype none

package grd_pkg;

    // field widths fixed by the symbol stream and the result format
    localparam int SYM_W   = 8;
    localparam int RUN_W   = 5;
    localparam int WIDTH_W = 8;
    localparam int TOTAL_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // largest row the column store is built for
    localparam int DEFAULT_MAX_WIDTH = 128;

    // run counters stop here
    localparam logic [RUN_W-1:0] RUN_SAT = 5'd31;

    // register reset values
    localparam logic [SYM_W-1:0]   RST_HORIZ_SYMBOL = 8'd104;
    localparam logic [SYM_W-1:0]   RST_VERT_SYMBOL  = 8'd118;
    localparam logic [RUN_W-1:0]   RST_RUN_LENGTH   = 5'd5;
    localparam logic [WIDTH_W-1:0] RST_ROW_WIDTH    = 8'd101;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HORIZ_SYMBOL = 2'd0,
        CFG_VERT_SYMBOL  = 2'd1,
        CFG_RUN_LENGTH   = 2'd2,
        CFG_ROW_WIDTH    = 2'd3
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic [SYM_W-1:0]   horiz_symbol;
        logic [SYM_W-1:0]   vert_symbol;
        logic [RUN_W-1:0]   run_length;
        logic [WIDTH_W-1:0] row_width;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic               row_done;
        logic [TOTAL_W-1:0] vert_total;
        logic [TOTAL_W-1:0] horiz_total;
    } t_result;

    // saturating run counter step
    function automatic logic [RUN_W-1:0] bump_run(input logic [RUN_W-1:0] r);
        bump_run = (r >= RUN_SAT) ? RUN_SAT : r + 1'b1;
    endfunction

    // saturating total step
    function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] t);
        bump_total = (t == {TOTAL_W{1'b1}}) ? t : t + 1'b1;
    endfunction

endpackage

`default_nettype wire

>>> hdl/grid_run_detector.sv
// top level of the grid run detector
// Counts horizontal and vertical runs in a padded raster that streams in one
// symbol per transaction, row after row. Every accepted symbol gives exactly
// one result transaction carrying the two running totals (both saturating)
// and a last-of-row flag on tlast. A symbol is accepted in every cycle while
// the result side keeps up: the column is read from the run store at accept,
// updated and written back, with a bypass when the next symbol falls in the
// same column; the result transaction is offered from the result register
// after the stage register. After reset the run store is cleared one column
// per cycle with tready held low meanwhile; configuration writes are taken at
// any time but should only be made while the block is idle.
`default_nettype none

module grid_run_detector #(
    parameter int MAX_WIDTH = grd_pkg::DEFAULT_MAX_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [grd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [grd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // symbol input
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [7:0]                        i_s_tdata,   // [7:0] symbol
    // result output
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [63:0]                            o_m_tdata,   // [31:0] horiz_total, [63:32] vert_total
    output logic                                   o_m_tlast    // row_done
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W = (CW + 1 > grd_pkg::WIDTH_W) ? CW + 1 : grd_pkg::WIDTH_W;
    localparam logic [CMP_W-1:0] MAXW_C    = CMP_W'(MAX_WIDTH);
    localparam logic [CW-1:0]    LAST_ADDR = CW'(MAX_WIDTH - 1);

    grd_pkg::t_cfg             r_cfg;
    logic [CW-1:0]             r_col_idx;
    logic [CW-1:0]             n_col_idx;
    logic                      r_clr_busy;
    logic [CW-1:0]             r_clr_addr;

    logic                      accept;
    logic                      can_take;
    logic                      last;
    logic [CMP_W-1:0]          rw_ext;
    logic [CMP_W-1:0]          eff_width;
    logic [CMP_W-1:0]          col_next;

    logic                      st_wr_en;
    logic [CW-1:0]             st_wr_addr;
    logic [grd_pkg::RUN_W-1:0] st_wr_data;
    logic                      mem_wr_en;
    logic [CW-1:0]             mem_wr_addr;
    logic [grd_pkg::RUN_W-1:0] mem_wr_data;
    logic [grd_pkg::RUN_W-1:0] rd_data;
    grd_pkg::t_result          result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.horiz_symbol <= grd_pkg::RST_HORIZ_SYMBOL;
            r_cfg.vert_symbol  <= grd_pkg::RST_VERT_SYMBOL;
            r_cfg.run_length   <= grd_pkg::RST_RUN_LENGTH;
            r_cfg.row_width    <= grd_pkg::RST_ROW_WIDTH;
        end else if (i_cfg_we) begin
            case (grd_pkg::t_cfg_idx'(i_cfg_index))
                grd_pkg::CFG_HORIZ_SYMBOL: r_cfg.horiz_symbol <= i_cfg_data;
                grd_pkg::CFG_VERT_SYMBOL:  r_cfg.vert_symbol  <= i_cfg_data;
                grd_pkg::CFG_RUN_LENGTH:
                    r_cfg.run_length <= i_cfg_data[grd_pkg::RUN_W-1:0];
                grd_pkg::CFG_ROW_WIDTH:    r_cfg.row_width    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input handshake
    assign o_s_tready = i_rst_n && !r_clr_busy && can_take;
    assign accept     = i_s_tvalid && o_s_tready;

    // column position and end of row
    always_comb begin
        rw_ext = CMP_W'(r_cfg.row_width);
        if (rw_ext == '0) begin
            eff_width = CMP_W'(1);
        end else if (rw_ext > MAXW_C) begin
            eff_width = MAXW_C;
        end else begin
            eff_width = rw_ext;
        end
        col_next  = CMP_W'(r_col_idx) + CMP_W'(1);
        last      = (col_next >= eff_width);
        n_col_idx = last ? '0 : col_next[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_idx <= '0;
        end else if (accept) begin
            r_col_idx <= n_col_idx;
        end
    end

    // clearing sweep of the run store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // store write port shared by the sweep and the write-back
    always_comb begin
        if (r_clr_busy) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_clr_addr;
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = st_wr_en;
            mem_wr_addr = st_wr_addr;
            mem_wr_data = st_wr_data;
        end
    end

    grd_colmem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_colmem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (r_col_idx),
        .o_rd_data (rd_data)
    );

    grd_stage #(
        .CW (CW)
    ) u_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (accept),
        .i_sym       (i_s_tdata),
        .i_col       (r_col_idx),
        .i_last      (last),
        .i_rd_data   (rd_data),
        .o_can_take  (can_take),
        .o_wr_en     (st_wr_en),
        .o_wr_addr   (st_wr_addr),
        .o_wr_data   (st_wr_data),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_result    (result)
    );

    // result packing
    assign o_m_tdata = {result.vert_total, result.horiz_total};
    assign o_m_tlast = result.row_done;

endmodule

`default_nettype wire

>>> hdl/grd_colmem.sv
// column run store: one write port, one registered read port
`default_nettype none

module grd_colmem #(
    parameter int DEPTH = grd_pkg::DEFAULT_MAX_WIDTH,
    parameter int AW    = 7
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [AW-1:0]            i_wr_addr,
    input  wire logic [grd_pkg::RUN_W-1:0] i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [AW-1:0]            i_rd_addr,
    output logic      [grd_pkg::RUN_W-1:0] o_rd_data
);

    logic [grd_pkg::RUN_W-1:0] r_mem [DEPTH];
    logic [grd_pkg::RUN_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hdl/grd_stage.sv
// update stage: run counters, totals and the result register
`default_nettype none

module grd_stage #(
    parameter int CW = 7
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire grd_pkg::t_cfg                i_cfg,
    // accepted symbol with its column position
    input  wire logic                         i_accept,
    input  wire logic [grd_pkg::SYM_W-1:0]    i_sym,
    input  wire logic [CW-1:0]                i_col,
    input  wire logic                         i_last,
    input  wire logic [grd_pkg::RUN_W-1:0]    i_rd_data,
    output logic                              o_can_take,
    // column store write-back
    output logic                              o_wr_en,
    output logic [CW-1:0]                     o_wr_addr,
    output logic [grd_pkg::RUN_W-1:0]         o_wr_data,
    // result
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output grd_pkg::t_result                  o_result
);

    logic                          r_s1_valid;
    logic [grd_pkg::SYM_W-1:0]     r_sym;
    logic [CW-1:0]                 r_col;
    logic                          r_last;
    logic                          r_fwd_hit;
    logic [grd_pkg::RUN_W-1:0]     r_fwd_val;
    logic [grd_pkg::RUN_W-1:0]     r_row_run;
    logic [grd_pkg::TOTAL_W-1:0]   r_horiz;
    logic [grd_pkg::TOTAL_W-1:0]   r_vert;
    logic                          r_out_valid;
    grd_pkg::t_result              r_out;

    logic                          s1_adv;
    logic [grd_pkg::RUN_W-1:0]     need;
    logic [grd_pkg::RUN_W-1:0]     col_run_old;
    logic [grd_pkg::RUN_W-1:0]     n_row_run;
    logic [grd_pkg::RUN_W-1:0]     n_col_run;
    logic [grd_pkg::TOTAL_W-1:0]   n_horiz;
    logic [grd_pkg::TOTAL_W-1:0]   n_vert;
    logic                          h_match;
    logic                          v_match;

    // stage moves on when the result register is free or being emptied
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_res_ready);
    assign o_can_take = !r_s1_valid || s1_adv;

    // run updates for the symbol in the stage register
    always_comb begin
        need        = (i_cfg.run_length == '0) ? grd_pkg::RUN_W'(1) : i_cfg.run_length;
        col_run_old = r_fwd_hit ? r_fwd_val : i_rd_data;
        h_match     = (r_sym == i_cfg.horiz_symbol);
        v_match     = (r_sym == i_cfg.vert_symbol);
        n_row_run   = h_match ? grd_pkg::bump_run(r_row_run) : '0;
        n_col_run   = v_match ? grd_pkg::bump_run(col_run_old) : '0;
        n_horiz     = (h_match && (n_row_run >= need)) ?
                      grd_pkg::bump_total(r_horiz) : r_horiz;
        n_vert      = (v_match && (n_col_run >= need)) ?
                      grd_pkg::bump_total(r_vert) : r_vert;
    end

    assign o_wr_en   = s1_adv;
    assign o_wr_addr = r_col;
    assign o_wr_data = n_col_run;

    // stage register and bypass of a write-back that the read missed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd_hit  <= s1_adv && (r_col == i_col);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sym     <= i_sym;
            r_col     <= i_col;
            r_last    <= i_last;
            r_fwd_val <= n_col_run;
        end
    end

    // row run and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_run <= '0;
            r_horiz   <= '0;
            r_vert    <= '0;
        end else if (s1_adv) begin
            r_row_run <= r_last ? '0 : n_row_run;
            r_horiz   <= n_horiz;
            r_vert    <= n_vert;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.horiz_total <= n_horiz;
            r_out.vert_total  <= n_vert;
            r_out.row_done    <= r_last;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

>>> hdl/grd_checker.sv
// port-level checks for the grid run detector and their binding
`default_nettype none

module grd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [63:0] o_m_tdata,
    input wire logic        o_m_tlast
);

    // no result is left pending once reset has been applied
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // input held off right after reset, while the run store is being cleared
    a_clear_hold: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready during store clearing");

    // a stalled result transaction keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast))
        else $error("stalled result changed");

    // totals never go down from one shown result to the next
    a_totals_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid ##1 o_m_tvalid |->
            (o_m_tdata[31:0] >= $past(o_m_tdata[31:0]))
            && (o_m_tdata[63:32] >= $past(o_m_tdata[63:32])))
        else $error("running total decreased");

endmodule

bind grid_run_detector grd_checker u_grd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
